/* hdl/swm_pkg.sv */
package swm_pkg;

    localparam int WINDOW = 5;
    localparam int SMP_W  = 32;
    localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W  = $clog2(WINDOW + 1);

    typedef struct packed {
        logic             load;
        logic             shift;
        logic [CNT_W-1:0] fill;
        logic [IDX_W-1:0] k;
    } t_cell_ctl;

endpackage

/* hdl/swm_cell.sv */
module swm_cell import swm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_cell_ctl               i_ctl,
    input  logic [IDX_W-1:0]        i_idx,
    input  logic                    i_wr,
    input  logic signed [SMP_W-1:0] i_sample,
    input  logic signed [SMP_W-1:0] i_nb_val,
    input  logic [IDX_W-1:0]        i_nb_idx,
    output logic signed [SMP_W-1:0] o_trv_val,
    output logic [IDX_W-1:0]        o_trv_idx,
    output logic signed [SMP_W-1:0] o_smp,
    output logic                    o_sel
);

    logic signed [SMP_W-1:0] r_smp;
    logic signed [SMP_W-1:0] r_trv_val;
    logic [IDX_W-1:0]        r_trv_idx;
    logic [IDX_W-1:0]        r_rank;
    logic                    w_trv_vld;
    logic                    w_hit;

    // ties broken by slot index so ranks are unique
    assign w_trv_vld = CNT_W'(r_trv_idx) < i_ctl.fill;
    assign w_hit     = w_trv_vld &&
                       ((r_trv_val < r_smp) || ((r_trv_val == r_smp) && (r_trv_idx < i_idx)));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_smp <= '0;
        end else if (i_ctl.load && i_wr) begin
            r_smp <= i_sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_trv_val <= i_wr ? i_sample : r_smp;
            r_trv_idx <= i_idx;
            r_rank    <= '0;
        end else if (i_ctl.shift) begin
            r_trv_val <= i_nb_val;
            r_trv_idx <= i_nb_idx;
            r_rank    <= r_rank + IDX_W'(w_hit);
        end
    end

    assign o_trv_val = r_trv_val;
    assign o_trv_idx = r_trv_idx;
    assign o_smp     = r_smp;
    assign o_sel     = (r_rank == i_ctl.k) && (CNT_W'(i_idx) < i_ctl.fill);

endmodule

/* hdl/sliding_window_median_core.sv */
// Median filter over a sliding window of WINDOW signed 32-bit samples. Each input word
// (op 0) writes its sample into the next slot of the window and returns the median of
// the valid samples; while the window fills, only samples seen so far count, and an even
// count gives the upper median. op 1 seeds every slot with the sample and marks the window
// full. Every word gives exactly one result word, with a flag for a full window. The samples
// sit in a ring of WINDOW cells; copies circulate around the ring one cell per cycle while
// each cell counts how many samples rank below its own. A word is written as the copies
// load, the copies circulate once around the ring, and the median is then loaded into the
// output register once the output side is free; no new word is taken until that is done.
module sliding_window_median_core import swm_pkg::*; (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic                    i_op,
    input  logic signed [SMP_W-1:0] i_sample,
    output logic                    o_valid,
    input  logic                    i_stall,
    output logic signed [SMP_W-1:0] o_median,
    output logic                    o_window_full
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_RANK = 3'b010,
        S_DONE = 3'b100
    } t_state;

    t_state                  r_state, n_state;
    logic [IDX_W-1:0]        r_step, n_step;
    logic [IDX_W-1:0]        r_wp, n_wp;
    logic [CNT_W-1:0]        r_fill, n_fill;
    logic                    r_out_vld, n_out_vld;
    logic signed [SMP_W-1:0] r_median;
    logic                    r_full;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_out_load;
    logic [WINDOW-1:0]       w_wr;
    logic [WINDOW-1:0]       w_sel;
    logic signed [SMP_W-1:0] w_trv_val [WINDOW];
    logic [IDX_W-1:0]        w_trv_idx [WINDOW];
    logic signed [SMP_W-1:0] w_smp     [WINDOW];
    logic signed [SMP_W-1:0] w_med;
    t_cell_ctl               w_ctl;

    assign o_stall    = (r_state != S_IDLE);
    assign w_accept   = i_valid && !o_stall;
    assign w_out_free = !r_out_vld || !i_stall;
    assign w_out_load = (r_state == S_DONE) && w_out_free;

    assign w_ctl.load  = w_accept;
    assign w_ctl.shift = (r_state == S_RANK);
    assign w_ctl.fill  = r_fill;
    assign w_ctl.k     = IDX_W'(r_fill >> 1);

    always_comb begin
        for (int i = 0; i < WINDOW; i++) begin
            w_wr[i] = i_op || (r_wp == IDX_W'(i));
        end
    end

    for (genvar g = 0; g < WINDOW; g++) begin : g_cell
        localparam int NB = (g + 1) % WINDOW;
        swm_cell u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (w_ctl),
            .i_idx     (IDX_W'(g)),
            .i_wr      (w_wr[g]),
            .i_sample  (i_sample),
            .i_nb_val  (w_trv_val[NB]),
            .i_nb_idx  (w_trv_idx[NB]),
            .o_trv_val (w_trv_val[g]),
            .o_trv_idx (w_trv_idx[g]),
            .o_smp     (w_smp[g]),
            .o_sel     (w_sel[g])
        );
    end

    always_comb begin
        w_med = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (w_sel[i]) begin
                w_med = w_med | w_smp[i];
            end
        end
    end

    always_comb begin
        n_state   = r_state;
        n_step    = r_step;
        n_wp      = r_wp;
        n_fill    = r_fill;
        n_out_vld = (r_out_vld && i_stall) || w_out_load;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_RANK;
                    n_step  = '0;
                    if (i_op) begin
                        n_wp   = '0;
                        n_fill = CNT_W'(WINDOW);
                    end else begin
                        n_wp = (r_wp == IDX_W'(WINDOW - 1)) ? '0 : r_wp + 1'b1;
                        if (r_fill != CNT_W'(WINDOW)) begin
                            n_fill = r_fill + 1'b1;
                        end
                    end
                end
            end
            S_RANK: begin
                n_step = r_step + 1'b1;
                if (r_step == IDX_W'(WINDOW - 1)) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_step    <= '0;
            r_wp      <= '0;
            r_fill    <= '0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_step    <= n_step;
            r_wp      <= n_wp;
            r_fill    <= n_fill;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_median <= w_med;
            r_full   <= (r_fill == CNT_W'(WINDOW));
        end
    end

    assign o_valid       = r_out_vld;
    assign o_median      = r_median;
    assign o_window_full = r_full;

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |-> $onehot(w_sel))
        else $error("median select not one-hot");

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill <= CNT_W'(WINDOW)) && (r_wp <= IDX_W'(WINDOW - 1)))
        else $error("fill count or write position out of range");

    a_accept_rank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_RANK) && (r_fill != '0))
        else $error("accepted word did not start ranking");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |=> o_valid && (o_window_full == (r_fill == CNT_W'(WINDOW))))
        else $error("output word not loaded");

endmodule

/* sim/tb_sliding_window_median_core.sv */
module tb_sliding_window_median_core;
    import swm_pkg::*;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_SEED = 1'b1;

    localparam logic signed [SMP_W-1:0] S_MAX = {1'b0, {(SMP_W-1){1'b1}}};
    localparam logic signed [SMP_W-1:0] S_MIN = {1'b1, {(SMP_W-1){1'b0}}};

    localparam int LATENCY    = WINDOW + 2;
    localparam int HOLD_CYC   = 400;
    localparam int MAX_PRINTS = 40;

    typedef struct packed {
        logic                    op;
        logic signed [SMP_W-1:0] sample;
    } t_sample_word;

    typedef struct packed {
        logic signed [SMP_W-1:0] median;
        logic                    full;
    } t_median_word;

    logic                    i_clk = 1'b0;
    logic                    i_rst_n = 1'b0;
    logic                    i_valid = 1'b0;
    logic                    o_stall;
    logic                    i_op = 1'b0;
    logic signed [SMP_W-1:0] i_sample = '0;
    logic                    o_valid;
    logic                    i_stall = 1'b0;
    logic signed [SMP_W-1:0] o_median;
    logic                    o_window_full;

    sliding_window_median_core uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_sample      (i_sample),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_median      (o_median),
        .o_window_full (o_window_full)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // filter state mirror
    logic signed [SMP_W-1:0] win_smp [WINDOW];
    int                      win_pos = 0;
    int                      win_fill = 0;

    t_sample_word sample_q [$];
    t_median_word median_q [$];

    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    logic hold_go = 1'b0;
    logic hold_on = 1'b0;

    int  err_cnt = 0;
    int  words_in = 0;
    int  seeds_in = 0;
    int  words_out = 0;
    int  full_stalls = 0;

    t_median_word got_exp;

    task automatic report_err(input string msg);
        err_cnt++;
        if (err_cnt <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    function automatic t_median_word median_after(input logic op,
                                                  input logic signed [SMP_W-1:0] s);
        logic signed [SMP_W-1:0] srt [WINDOW];
        logic signed [SMP_W-1:0] key;
        int                      j;
        t_median_word            r;
        if (op == OP_SEED) begin
            for (int i = 0; i < WINDOW; i++) win_smp[i] = s;
            win_pos  = 0;
            win_fill = WINDOW;
            r.median = s;
        end else begin
            win_smp[win_pos] = s;
            if (win_fill < WINDOW) win_fill++;
            win_pos = (win_pos + 1 == WINDOW) ? 0 : win_pos + 1;
            for (int i = 0; i < win_fill; i++) srt[i] = win_smp[i];
            for (int i = 1; i < win_fill; i++) begin
                key = srt[i];
                j = i;
                while (j > 0 && srt[j-1] > key) begin
                    srt[j] = srt[j-1];
                    j--;
                end
                srt[j] = key;
            end
            r.median = srt[win_fill / 2];
        end
        r.full = (win_fill == WINDOW);
        return r;
    endfunction

    function automatic t_sample_word rand_word();
        t_sample_word w;
        w.op = ($urandom_range(0, 99) < 8) ? OP_SEED : OP_PUSH;
        case ($urandom_range(0, 3))
            0: w.sample = $urandom;
            1: w.sample = $urandom_range(0, 8) - 4;
            2: begin
                case ($urandom_range(0, 4))
                    0: w.sample = S_MIN;
                    1: w.sample = S_MAX;
                    2: w.sample = '0;
                    3: w.sample = -1;
                    default: w.sample = 1;
                endcase
            end
            default: w.sample = ($urandom_range(0, 1) ? S_MAX : S_MIN) ^ $urandom_range(0, 7);
        endcase
        return w;
    endfunction

    task automatic add_word(input logic op, input logic signed [SMP_W-1:0] s);
        t_sample_word w;
        w.op = op;
        w.sample = s;
        sample_q.push_back(w);
    endtask

    task automatic drain();
        while (sample_q.size() != 0 || i_valid || median_q.size() != 0)
            @(negedge i_clk);
        repeat (2 * LATENCY) @(negedge i_clk);
    endtask

    task automatic run_phase(input int n, input int snd, input int rcv);
        send_idle_pct  = snd;
        recv_stall_pct = rcv;
        for (int i = 0; i < n; i++) sample_q.push_back(rand_word());
        drain();
    endtask

    // sender
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || !o_stall) begin
            if (i_valid) begin
                median_q.push_back(median_after(i_op, i_sample));
                words_in++;
                if (i_op == OP_SEED) seeds_in++;
            end
            if (sample_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_valid  <= 1'b1;
                i_op     <= sample_q[0].op;
                i_sample <= sample_q[0].sample;
                void'(sample_q.pop_front());
            end else begin
                i_valid  <= 1'b0;
                i_op     <= 1'($urandom_range(0, 1));
                i_sample <= $urandom;
            end
        end else begin
            full_stalls++;
        end
    end

    // receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= hold_on || ($urandom_range(0, 99) < recv_stall_pct);
    end

    initial begin
        wait (hold_go);
        @(posedge i_clk);
        hold_on <= 1'b1;
        repeat (HOLD_CYC) @(posedge i_clk);
        hold_on <= 1'b0;
    end

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (median_q.size() == 0) begin
                report_err($sformatf("unexpected word median=%0d full=%0b",
                                     o_median, o_window_full));
            end else begin
                got_exp = median_q.pop_front();
                words_out++;
                if (o_median !== got_exp.median)
                    report_err($sformatf("word %0d: median %0d, want %0d",
                                         words_out, o_median, got_exp.median));
                if (o_window_full !== got_exp.full)
                    report_err($sformatf("word %0d: window_full %0b, want %0b",
                                         words_out, o_window_full, got_exp.full));
            end
        end
    end

    initial begin
        for (int i = 0; i < WINDOW; i++) win_smp[i] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // filling window from reset, then wrap, then seeds
        add_word(OP_PUSH, '0);
        add_word(OP_PUSH, S_MAX);
        add_word(OP_PUSH, S_MIN);
        add_word(OP_PUSH, -1);
        add_word(OP_PUSH, 1);
        add_word(OP_PUSH, 100);
        add_word(OP_PUSH, -100);
        add_word(OP_PUSH, 7);
        add_word(OP_PUSH, 7);
        add_word(OP_PUSH, 7);
        add_word(OP_PUSH, S_MAX);
        add_word(OP_SEED, S_MIN);
        add_word(OP_PUSH, S_MAX);
        add_word(OP_PUSH, S_MAX);
        add_word(OP_PUSH, S_MAX);
        add_word(OP_SEED, S_MAX);
        add_word(OP_PUSH, S_MIN);
        add_word(OP_SEED, -1);
        add_word(OP_PUSH, '0);
        add_word(OP_SEED, 32'sh5555_5555);
        add_word(OP_PUSH, 32'shAAAA_AAAA);
        add_word(OP_PUSH, 32'sh5555_5555);
        run_phase(0, 0, 0);

        run_phase(300, 0, 0);
        run_phase(200, 88, 0);
        run_phase(200, 0, 88);
        run_phase(300, 25, 25);
        hold_go = 1'b1;
        run_phase(200, 0, 0);
        run_phase(100, 10, 50);

        $display("%0d words in (%0d seeds), %0d results checked, %0d input stall cycles",
                 words_in, seeds_in, words_out, full_stalls);
        $display("idle mixes: none, sender, receiver, both, long output hold-off");
        if (err_cnt == 0)
            $display("tb_sliding_window_median_core: clean");
        else
            $display("tb_sliding_window_median_core: errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("timeout: %0d results still expected", median_q.size());
        $display("tb_sliding_window_median_core: errors");
        $finish;
    end

endmodule

/* files.f */
hdl/swm_pkg.sv
hdl/swm_cell.sv
hdl/sliding_window_median_core.sv
sim/tb_sliding_window_median_core.sv
